FILE: rtl/core/npls_pkg.sv
// Package for the nested piecewise-linear spline core.
// Opcode and status codes, stream field widths and datapath widths.
// No dependencies.
package npls_pkg;

    localparam logic [1:0] OP_LOAD_OUTER = 2'd0;
    localparam logic [1:0] OP_LOAD_INNER = 2'd1;
    localparam logic [1:0] OP_EVALUATE   = 2'd2;
    localparam logic [1:0] OP_RESERVED   = 2'd3;

    localparam logic [1:0] ST_INTERP  = 2'd0;
    localparam logic [1:0] ST_CLAMPED = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;

    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 32;
    localparam int TUSER_W   = 2;
    localparam int CFG_W     = 4;

    localparam int QUO_W  = 17;
    localparam int REM_W  = 34;
    localparam int PROD_W = 51;

    typedef logic signed [31:0] q16_t;
    typedef logic signed [32:0] q16_wide_t;

endpackage

FILE: rtl/core/nested_piecewise_linear_spline_core.sv
// A load completes in its accepting cycle; an evaluate's result waits on the serial
// breakpoint scans (one memory read a cycle) and on up to three 17-step passes of the
// shared restoring divider.
// One item at a time: s_axis_tready is high only while idle, so a new item waits until the
// evaluate before it is done, plus any stall while its result waits in the output register.
// Synchronous active-low reset clears control, count and lengths; memories are not cleared.
module nested_piecewise_linear_spline_core #(
    parameter int OUTER_POINTS = 8,
    parameter int INNER_POINTS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [npls_pkg::CFG_W-1:0]      cfg_data,      // outer_count
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // outer_index[2:0], inner_index[5:3], point_x[37:6], point_y[69:38],
    // inner_points[73:70], query_primary[105:74], query_secondary[137:106]
    input  logic [npls_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  logic [npls_pkg::TUSER_W-1:0]    s_axis_tuser,  // opcode
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [npls_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // value
    output logic [npls_pkg::TUSER_W-1:0]    m_axis_tuser   // status
);

    localparam int OW  = $clog2(OUTER_POINTS);
    localparam int NW  = $clog2(OUTER_POINTS + 1);
    localparam int LW  = $clog2(INNER_POINTS + 1);
    localparam int IAW = $clog2(OUTER_POINTS * INNER_POINTS);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_O_LO   = 4'd1;
    localparam logic [3:0] S_O_HI   = 4'd2;
    localparam logic [3:0] S_O_SCAN = 4'd3;
    localparam logic [3:0] S_I_STRT = 4'd4;
    localparam logic [3:0] S_I_LO   = 4'd5;
    localparam logic [3:0] S_I_HI   = 4'd6;
    localparam logic [3:0] S_I_SCAN = 4'd7;
    localparam logic [3:0] S_B_INIT = 4'd8;
    localparam logic [3:0] S_B_DIV  = 4'd9;
    localparam logic [3:0] S_B_MUL  = 4'd10;
    localparam logic [3:0] S_B_ADD  = 4'd11;
    localparam logic [3:0] S_SMP    = 4'd12;
    localparam logic [3:0] S_DONE   = 4'd13;

    // storage
    npls_pkg::q16_t outer_x_mem [OUTER_POINTS];
    npls_pkg::q16_t outer_y_mem [OUTER_POINTS];
    npls_pkg::q16_t inner_x_mem [OUTER_POINTS*INNER_POINTS];
    npls_pkg::q16_t inner_y_mem [OUTER_POINTS*INNER_POINTS];
    logic [LW-1:0]  inner_len_reg [OUTER_POINTS];
    logic [npls_pkg::CFG_W-1:0] outer_count_reg;

    npls_pkg::q16_t ox_rd_reg, oy_rd_reg, ix_rd_reg, iy_rd_reg;
    logic [OW-1:0]  o_raddr;
    logic [IAW-1:0] i_raddr;

    // input fields
    logic [1:0]     in_op;
    logic [2:0]     in_oi, in_ii;
    npls_pkg::q16_t in_px, in_py, in_qp, in_qs;
    logic [3:0]     in_ilen;
    logic           s_xfer, oi_ok, ii_ok;
    logic [NW-1:0]  n_sat;
    logic [LW-1:0]  ilen_sat, m_len;

    // sequencer state
    logic [3:0]     state_reg, state_next;
    logic [NW-1:0]  idx_reg, idx_next, n_reg, n_next;
    logic [OW-1:0]  row_reg, row_next;
    logic [LW-1:0]  j_reg, j_next;
    logic [1:0]     phase_reg, phase_next;
    npls_pkg::q16_t qp_reg, qp_next, qs_reg, qs_next;
    npls_pkg::q16_t oprev_reg, oprev_next, ox0_reg, ox0_next, ox1_reg, ox1_next;
    npls_pkg::q16_t ipx_reg, ipx_next, ipy_reg, ipy_next;
    npls_pkg::q16_t a_reg, a_next, smp_reg, smp_next;
    npls_pkg::q16_t y0_reg, y0_next, y1_reg, y1_next;
    npls_pkg::q16_wide_t off_reg, off_next, span_reg, span_next;
    logic [npls_pkg::REM_W-1:0] rem_reg, rem_next, trial;
    logic [npls_pkg::QUO_W-1:0] quo_reg, quo_next;
    logic [4:0]     cnt_reg, cnt_next;
    logic signed [npls_pkg::PROD_W-1:0] prod_reg, prod_next;
    npls_pkg::q16_wide_t ydiff;
    npls_pkg::q16_t res_val_reg, res_val_next;
    logic [1:0]     res_st_reg, res_st_next;
    logic           m_valid_reg, m_valid_next;
    npls_pkg::q16_t m_val_reg, m_val_next;
    logic [1:0]     m_st_reg, m_st_next;

    assign in_op   = s_axis_tuser;
    assign in_oi   = s_axis_tdata[2:0];
    assign in_ii   = s_axis_tdata[5:3];
    assign in_px   = s_axis_tdata[37:6];
    assign in_py   = s_axis_tdata[69:38];
    assign in_ilen = s_axis_tdata[73:70];
    assign in_qp   = s_axis_tdata[105:74];
    assign in_qs   = s_axis_tdata[137:106];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign oi_ok = (32'(in_oi) < OUTER_POINTS);
    assign ii_ok = (32'(in_ii) < INNER_POINTS);
    assign n_sat = (32'(outer_count_reg) > OUTER_POINTS) ? NW'(OUTER_POINTS)
                                                        : NW'(outer_count_reg);
    assign ilen_sat = (32'(in_ilen) > INNER_POINTS) ? LW'(INNER_POINTS) : LW'(in_ilen);
    assign m_len    = inner_len_reg[row_reg];

    assign o_raddr = OW'(idx_next);
    assign i_raddr = IAW'(32'(row_next) * INNER_POINTS + 32'(j_next));

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_val_reg;
    assign m_axis_tuser  = m_st_reg;

    // memories
    always_ff @(posedge aclk) begin
        if (s_xfer && in_op == npls_pkg::OP_LOAD_OUTER && oi_ok) begin
            outer_x_mem[OW'(in_oi)] <= in_px;
            outer_y_mem[OW'(in_oi)] <= in_py;
        end
        if (s_xfer && in_op == npls_pkg::OP_LOAD_INNER && oi_ok && ii_ok) begin
            inner_x_mem[IAW'(32'(in_oi) * INNER_POINTS + 32'(in_ii))] <= in_px;
            inner_y_mem[IAW'(32'(in_oi) * INNER_POINTS + 32'(in_ii))] <= in_py;
        end
        ox_rd_reg <= outer_x_mem[o_raddr];
        oy_rd_reg <= outer_y_mem[o_raddr];
        ix_rd_reg <= inner_x_mem[i_raddr];
        iy_rd_reg <= inner_y_mem[i_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outer_count_reg <= '0;
            for (int k = 0; k < OUTER_POINTS; k++) begin
                inner_len_reg[k] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                outer_count_reg <= cfg_data;
            end
            if (s_xfer && in_op == npls_pkg::OP_LOAD_OUTER && oi_ok) begin
                inner_len_reg[OW'(in_oi)] <= ilen_sat;
            end
        end
    end

    assign trial = (cnt_reg == 5'd16) ? rem_reg : {rem_reg[npls_pkg::REM_W-2:0], 1'b0};
    assign ydiff = {y1_reg[31], y1_reg} - {y0_reg[31], y0_reg};

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        n_next       = n_reg;
        row_next     = row_reg;
        j_next       = j_reg;
        phase_next   = phase_reg;
        qp_next      = qp_reg;
        qs_next      = qs_reg;
        oprev_next   = oprev_reg;
        ox0_next     = ox0_reg;
        ox1_next     = ox1_reg;
        ipx_next     = ipx_reg;
        ipy_next     = ipy_reg;
        a_next       = a_reg;
        smp_next     = smp_reg;
        y0_next      = y0_reg;
        y1_next      = y1_reg;
        off_next     = off_reg;
        span_next    = span_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        prod_next    = prod_reg;
        res_val_next = res_val_reg;
        res_st_next  = res_st_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_val_next   = m_val_reg;
        m_st_next    = m_st_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_xfer && in_op == npls_pkg::OP_EVALUATE) begin
                    qp_next  = in_qp;
                    qs_next  = in_qs;
                    n_next   = n_sat;
                    idx_next = '0;
                    if (n_sat == '0) begin
                        res_val_next = '0;
                        res_st_next  = npls_pkg::ST_EMPTY;
                        state_next   = S_DONE;
                    end else begin
                        state_next = S_O_LO;
                    end
                end
            end
            S_O_LO: begin
                if (qp_reg <= ox_rd_reg) begin
                    res_val_next = oy_rd_reg;
                    res_st_next  = npls_pkg::ST_CLAMPED;
                    state_next   = S_DONE;
                end else begin
                    oprev_next = ox_rd_reg;
                    idx_next   = n_reg - 1'b1;
                    state_next = S_O_HI;
                end
            end
            S_O_HI: begin
                if (qp_reg >= ox_rd_reg) begin
                    res_val_next = oy_rd_reg;
                    res_st_next  = npls_pkg::ST_CLAMPED;
                    state_next   = S_DONE;
                end else begin
                    idx_next   = NW'(1);
                    state_next = S_O_SCAN;
                end
            end
            S_O_SCAN: begin
                if (qp_reg >= oprev_reg && qp_reg <= ox_rd_reg) begin
                    ox0_next   = oprev_reg;
                    ox1_next   = ox_rd_reg;
                    row_next   = OW'(idx_reg - 1'b1);
                    phase_next = 2'd0;
                    state_next = S_I_STRT;
                end else if (idx_reg == n_reg - 1'b1) begin
                    res_val_next = '0;
                    res_st_next  = npls_pkg::ST_EMPTY;
                    state_next   = S_DONE;
                end else begin
                    oprev_next = ox_rd_reg;
                    idx_next   = idx_reg + 1'b1;
                end
            end
            S_I_STRT: begin
                if (m_len == '0) begin
                    smp_next   = '0;
                    state_next = S_SMP;
                end else begin
                    j_next     = '0;
                    state_next = S_I_LO;
                end
            end
            S_I_LO: begin
                if (qs_reg <= ix_rd_reg) begin
                    smp_next   = iy_rd_reg;
                    state_next = S_SMP;
                end else begin
                    ipx_next   = ix_rd_reg;
                    ipy_next   = iy_rd_reg;
                    j_next     = m_len - 1'b1;
                    state_next = S_I_HI;
                end
            end
            S_I_HI: begin
                if (qs_reg >= ix_rd_reg) begin
                    smp_next   = iy_rd_reg;
                    state_next = S_SMP;
                end else begin
                    j_next     = LW'(1);
                    state_next = S_I_SCAN;
                end
            end
            S_I_SCAN: begin
                if (qs_reg >= ipx_reg && qs_reg <= ix_rd_reg) begin
                    y0_next    = ipy_reg;
                    y1_next    = iy_rd_reg;
                    off_next   = {qs_reg[31], qs_reg} - {ipx_reg[31], ipx_reg};
                    span_next  = {ix_rd_reg[31], ix_rd_reg} - {ipx_reg[31], ipx_reg};
                    state_next = S_B_INIT;
                end else if (j_reg == m_len - 1'b1) begin
                    smp_next   = '0;
                    state_next = S_SMP;
                end else begin
                    ipx_next = ix_rd_reg;
                    ipy_next = iy_rd_reg;
                    j_next   = j_reg + 1'b1;
                end
            end
            S_B_INIT: begin
                if (span_reg <= 0 || off_reg <= 0) begin
                    smp_next   = y0_reg;
                    state_next = S_SMP;
                end else begin
                    rem_next   = (off_reg > span_reg) ? npls_pkg::REM_W'(span_reg)
                                                      : npls_pkg::REM_W'(off_reg);
                    quo_next   = '0;
                    cnt_next   = 5'd16;
                    state_next = S_B_DIV;
                end
            end
            S_B_DIV: begin
                if (trial >= npls_pkg::REM_W'(span_reg)) begin
                    rem_next = trial - npls_pkg::REM_W'(span_reg);
                    quo_next = {quo_reg[npls_pkg::QUO_W-2:0], 1'b1};
                end else begin
                    rem_next = trial;
                    quo_next = {quo_reg[npls_pkg::QUO_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = S_B_MUL;
                end
            end
            S_B_MUL: begin
                prod_next  = npls_pkg::PROD_W'(ydiff * $signed({1'b0, quo_reg}));
                state_next = S_B_ADD;
            end
            S_B_ADD: begin
                smp_next   = y0_reg + prod_reg[47:16];
                state_next = S_SMP;
            end
            S_SMP: begin
                case (phase_reg)
                    2'd0: begin
                        a_next     = smp_reg;
                        row_next   = row_reg + 1'b1;
                        phase_next = 2'd1;
                        state_next = S_I_STRT;
                    end
                    2'd1: begin
                        y0_next    = a_reg;
                        y1_next    = smp_reg;
                        off_next   = {qp_reg[31], qp_reg} - {ox0_reg[31], ox0_reg};
                        span_next  = {ox1_reg[31], ox1_reg} - {ox0_reg[31], ox0_reg};
                        phase_next = 2'd2;
                        state_next = S_B_INIT;
                    end
                    default: begin
                        res_val_next = smp_reg;
                        res_st_next  = npls_pkg::ST_INTERP;
                        state_next   = S_DONE;
                    end
                endcase
            end
            S_DONE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_val_next   = res_val_reg;
                    m_st_next    = res_st_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        n_reg       <= n_next;
        row_reg     <= row_next;
        j_reg       <= j_next;
        phase_reg   <= phase_next;
        qp_reg      <= qp_next;
        qs_reg      <= qs_next;
        oprev_reg   <= oprev_next;
        ox0_reg     <= ox0_next;
        ox1_reg     <= ox1_next;
        ipx_reg     <= ipx_next;
        ipy_reg     <= ipy_next;
        a_reg       <= a_next;
        smp_reg     <= smp_next;
        y0_reg      <= y0_next;
        y1_reg      <= y1_next;
        off_reg     <= off_next;
        span_reg    <= span_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        prod_reg    <= prod_next;
        res_val_reg <= res_val_next;
        res_st_reg  <= res_st_next;
        m_val_reg   <= m_val_next;
        m_st_reg    <= m_st_next;
    end

endmodule

FILE: rtl/core/npls_checker.sv
// Port-level checks for the nested piecewise-linear spline core.
// Depends on npls_pkg; bound to nested_piecewise_linear_spline_core.
module npls_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [npls_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input logic [npls_pkg::TUSER_W-1:0]    m_axis_tuser
);

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result transfer changed");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tuser <= npls_pkg::ST_EMPTY)
        else $error("undefined status code");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == npls_pkg::ST_EMPTY |-> m_axis_tdata == '0)
        else $error("empty status with nonzero value");

endmodule

bind nested_piecewise_linear_spline_core npls_checker u_npls_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
